// ----- sv/dtti_pkg.sv -----
// ----------------------------------------------------------------------------
// dtti_pkg: shared types and codes for the decimal text parser
// Character classes, mode codes and the transaction structs passed between
// the front end, the parser back end and the result queue.
// ----------------------------------------------------------------------------
package dtti_pkg;

  // Mode register codes; any other code is handled as signed 64-bit
  localparam logic [1:0] MODE_S32 = 2'd0;
  localparam logic [1:0] MODE_U32 = 2'd1;
  localparam logic [1:0] MODE_S64 = 2'd2;

  // Character classes
  localparam logic [2:0] KIND_SPACE = 3'd0;
  localparam logic [2:0] KIND_DIGIT = 3'd1;
  localparam logic [2:0] KIND_PLUS  = 3'd2;
  localparam logic [2:0] KIND_MINUS = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  // Byte values of interest
  localparam logic [7:0] CH_TAB  = 8'd9;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_SP   = 8'd32;
  localparam logic [7:0] CH_PLUS = 8'd43;
  localparam logic [7:0] CH_MIN  = 8'd45;
  localparam logic [7:0] CH_0    = 8'd48;
  localparam logic [7:0] CH_9    = 8'd57;

  // Classified character, stamped with the mode current at its transaction
  typedef struct packed {
    logic       is_end;
    logic [2:0] kind;
    logic [3:0] digit;
    logic [1:0] mode;
  } tok_t;

  // One parse result
  typedef struct packed {
    logic               accepted;
    logic signed [63:0] value;
  } res_t;

endpackage

// ----- sv/dtti_front.sv -----
// ----------------------------------------------------------------------------
// dtti_front: character classifier and token queue
// Classifies each accepted character and holds up to two tokens between the
// classifier and the parser back end, so each side can stall on its own.
// ----------------------------------------------------------------------------
module dtti_front import dtti_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_code,
  input  logic       in_is_end,
  input  logic [1:0] mode,
  output logic       tok_vld,
  output tok_t       tok,
  input  logic       tok_pop
);

  tok_t       tok_q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  tok_t       cls;
  logic       do_push, do_pop;

  // Classify the incoming byte
  always_comb begin
    cls        = '0;
    cls.is_end = in_is_end;
    cls.mode   = mode;
    cls.digit  = 4'(in_char_code - CH_0);
    if (in_char_code >= CH_0 && in_char_code <= CH_9) begin
      cls.kind = KIND_DIGIT;
    end else if (in_char_code == CH_SP ||
                 (in_char_code >= CH_TAB && in_char_code <= CH_CR)) begin
      cls.kind = KIND_SPACE;
    end else if (in_char_code == CH_PLUS) begin
      cls.kind = KIND_PLUS;
    end else if (in_char_code == CH_MIN) begin
      cls.kind = KIND_MINUS;
    end else begin
      cls.kind = KIND_OTHER;
    end
  end

  // Queue control
  assign full    = (cnt_r == 2'd2);
  assign tok_vld = (cnt_r != 2'd0);
  assign tok     = tok_q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = tok_pop && tok_vld;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Token storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      tok_q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- sv/dtti_back.sv -----
// ----------------------------------------------------------------------------
// dtti_back: scan state machine and decimal accumulator
// Takes one token per cycle unless a full result queue holds the end token, tracks the
// scan phase, accumulates magnitude times ten plus digit, forms the result on the end token.
// ----------------------------------------------------------------------------
module dtti_back import dtti_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic tok_vld,
  input  tok_t tok,
  output logic tok_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_SIGN  = 3'd1;
  localparam logic [2:0] PH_DIGIT = 3'd2;
  localparam logic [2:0] PH_TRAIL = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic        ovf_r, ovf_nxt;
  logic        saw_r, saw_nxt;

  logic [67:0] acc_sum;
  logic        acc_ovf;
  logic [63:0] limit;
  logic        in_rng;
  logic        ok;
  logic        is_sign;

  // Token consumption: the end token waits for room in the result queue
  assign tok_pop  = tok_vld && (!tok.is_end || !res_full);
  assign res_push = tok_pop && tok.is_end;
  assign is_sign  = (tok.kind == KIND_PLUS || tok.kind == KIND_MINUS);

  // magnitude * 10 + digit, with carry-out as overflow
  assign acc_sum = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1) + 68'(tok.digit);
  assign acc_ovf = (acc_sum[67:64] != 4'd0);

  // Range check against the mode of the end token
  always_comb begin
    case (tok.mode)
      MODE_S32: limit = neg_r ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      MODE_U32: limit = neg_r ? 64'h0 : 64'h0000_0000_FFFF_FFFF;
      default:  limit = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
    in_rng = !ovf_r && (mag_r <= limit);
  end

  // End-of-string verdict
  always_comb begin
    ok = 1'b0;
    if (saw_r) begin
      if (phase_r == PH_LEAD) begin
        ok = (tok.mode != MODE_U32);
      end else if (phase_r == PH_DIGIT || phase_r == PH_TRAIL) begin
        ok = in_rng;
      end
    end
    res.accepted = ok;
    if (ok && phase_r != PH_LEAD) begin
      res.value = neg_r ? -$signed(mag_r) : $signed(mag_r);
    end else begin
      res.value = '0;
    end
  end

  // Scan state machine
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ovf_nxt   = ovf_r;
    saw_nxt   = saw_r;
    if (tok_pop && tok.is_end) begin
      phase_nxt = PH_LEAD;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
      ovf_nxt   = 1'b0;
      saw_nxt   = 1'b0;
    end else if (tok_pop) begin
      saw_nxt = 1'b1;
      // digit accumulate, shared by the phases that take a digit
      if (tok.kind == KIND_DIGIT &&
          (phase_r == PH_LEAD || phase_r == PH_SIGN || phase_r == PH_DIGIT) &&
          !ovf_r) begin
        if (acc_ovf) begin
          ovf_nxt = 1'b1;
          mag_nxt = '1;
        end else begin
          mag_nxt = acc_sum[63:0];
        end
      end
      unique case (phase_r)
        PH_LEAD: begin
          if (tok.kind == KIND_SPACE) begin
            phase_nxt = PH_LEAD;
          end else if (tok.kind == KIND_DIGIT) begin
            phase_nxt = PH_DIGIT;
          end else if (is_sign && tok.mode != MODE_U32) begin
            neg_nxt   = (tok.kind == KIND_MINUS);
            phase_nxt = PH_SIGN;
          end else begin
            phase_nxt = PH_ERR;
          end
        end
        PH_SIGN: begin
          phase_nxt = (tok.kind == KIND_DIGIT) ? PH_DIGIT : PH_ERR;
        end
        PH_DIGIT: begin
          if (tok.kind == KIND_DIGIT) begin
            phase_nxt = PH_DIGIT;
          end else if (tok.kind == KIND_SPACE) begin
            phase_nxt = PH_TRAIL;
          end else begin
            phase_nxt = PH_ERR;
          end
        end
        PH_TRAIL: begin
          phase_nxt = (tok.kind == KIND_SPACE) ? PH_TRAIL : PH_ERR;
        end
        default: begin
          phase_nxt = PH_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      ovf_r   <= 1'b0;
      saw_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      ovf_r   <= ovf_nxt;
      saw_r   <= saw_nxt;
    end
  end

endmodule

// ----- sv/decimal_text_to_integer.sv -----
// ----------------------------------------------------------------------------
// decimal_text_to_integer: streaming base-10 string to integer parser
// Parses a character stream closed by an end marker into a signed 32-bit,
// unsigned 32-bit or signed 64-bit value, or a reject.
//
//   channel | ports                                | handshake
//   --------+--------------------------------------+--------------------------
//   input   | in_char_code, in_is_end              | push / full
//   result  | out_accepted, out_value              | pop / empty
//   config  | cfg_wdata (mode)                     | cfg_we, no wait
//
// One character transaction per cycle while full is low; the limit is the single
// multiply-by-ten accumulate in the parser back end.
// An accepted end transaction is registered in the token queue; its result is
// written into the result queue once the back end takes that token.
// Reset clears the queues, the scan state and the mode (signed 32-bit).
// A full result queue holds the end token in the back end; tokens behind it
// wait, and once the two-entry token queue fills, full stalls the input.
// ----------------------------------------------------------------------------
module decimal_text_to_integer import dtti_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_char_code,
  input  logic               in_is_end,
  output logic               empty,
  input  logic               pop,
  output logic               out_accepted,
  output logic signed [63:0] out_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata
);

  logic [1:0] mode_r;
  logic       tok_vld;
  tok_t       tok;
  logic       tok_pop;
  logic       res_full;
  logic       res_push;
  res_t       res;

  res_t       res_q_r [2];
  logic       res_wr_r, res_rd_r;
  logic [1:0] res_cnt_r;
  logic       do_pop;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_S32;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  dtti_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_char_code (in_char_code),
    .in_is_end    (in_is_end),
    .mode         (mode_r),
    .tok_vld      (tok_vld),
    .tok          (tok),
    .tok_pop      (tok_pop)
  );

  dtti_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_vld  (tok_vld),
    .tok      (tok),
    .tok_pop  (tok_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  // Result queue, two entries
  assign res_full     = (res_cnt_r == 2'd2);
  assign empty        = (res_cnt_r == 2'd0);
  assign do_pop       = pop && !empty;
  assign out_accepted = res_q_r[res_rd_r].accepted;
  assign out_value    = res_q_r[res_rd_r].value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_r <= ~res_wr_r;
      end
      if (do_pop) begin
        res_rd_r <= ~res_rd_r;
      end
      res_cnt_r <= res_cnt_r + 2'(res_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[res_wr_r] <= res;
    end
  end

endmodule

// ----- verif/tb_decimal_text_to_integer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_text_to_integer: self-checking bench for the decimal text parser
// Streams character strings through the parser in all four mode codes and
// predicts each end-of-string result with a local scanner. Directed strings
// cover the corner cases. Random strings are mostly well-formed numbers,
// boundary values among them, plus broken strings and byte noise. Both
// queue sides idle at random. One long result hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_integer;
  import dtti_pkg::*;

  // Unused mode code, handled by the block as signed 64-bit
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [2:0] {
    SCAN_LEAD, SCAN_SIGN, SCAN_DIGIT, SCAN_TRAIL, SCAN_ERR
  } scan_e;

  typedef logic [7:0] text_t[$];

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [7:0]         in_char_code;
  logic               in_is_end;
  logic               empty;
  logic               pop;
  logic               out_accepted;
  logic signed [63:0] out_value;
  logic               cfg_we;
  logic [1:0]         cfg_wdata;

  // Scanner state of the prediction
  logic [1:0]  scan_mode;
  scan_e       scan_phase;
  logic        scan_neg;
  logic [63:0] scan_mag;
  logic        scan_ovf;
  logic        scan_seen;

  res_t parse_due[$];
  res_t due_head;

  bit calm;
  bit hold_req;
  int err_count;
  int chars_sent;
  int strings_sent;
  int results_seen;
  int stall_cycles;
  int quiet;

  logic [7:0] blank_bytes [6] = '{CH_TAB, 8'd10, 8'd11, 8'd12, CH_CR, CH_SP};
  string bound_texts [12] = '{
    "0", "2147483647", "2147483648", "2147483649", "4294967295", "4294967296",
    "9223372036854775807", "9223372036854775808", "9223372036854775809",
    "18446744073709551615", "18446744073709551616", "0000000000000000000000000042"
  };

  decimal_text_to_integer DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_char_code (in_char_code),
    .in_is_end    (in_is_end),
    .empty        (empty),
    .pop          (pop),
    .out_accepted (out_accepted),
    .out_value    (out_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Prediction
  task automatic add_digit(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - CH_0);
    if (!scan_ovf) begin
      if (scan_mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
        scan_ovf = 1'b1;
        scan_mag = 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
        scan_mag = scan_mag * 64'd10 + d;
      end
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last);
    logic is_dig;
    logic is_sp;
    logic fits;
    res_t r;
    is_dig = c >= CH_0 && c <= CH_9;
    is_sp  = c == CH_SP || (c >= CH_TAB && c <= CH_CR);
    if (!last) begin
      scan_seen = 1'b1;
      case (scan_phase)
        SCAN_LEAD: begin
          if (is_sp) begin
            scan_phase = SCAN_LEAD;
          end else if (is_dig) begin
            add_digit(c);
            scan_phase = SCAN_DIGIT;
          end else if ((c == CH_PLUS || c == CH_MIN) && scan_mode != MODE_U32) begin
            scan_neg   = c == CH_MIN;
            scan_phase = SCAN_SIGN;
          end else begin
            scan_phase = SCAN_ERR;
          end
        end
        SCAN_SIGN: begin
          if (is_dig) begin
            add_digit(c);
            scan_phase = SCAN_DIGIT;
          end else begin
            scan_phase = SCAN_ERR;
          end
        end
        SCAN_DIGIT: begin
          if (is_dig) add_digit(c);
          else if (is_sp) scan_phase = SCAN_TRAIL;
          else scan_phase = SCAN_ERR;
        end
        SCAN_TRAIL: begin
          if (!is_sp) scan_phase = SCAN_ERR;
        end
        default: scan_phase = SCAN_ERR;
      endcase
    end else begin
      r.accepted = 1'b0;
      r.value    = '0;
      if (scan_seen) begin
        if (scan_phase == SCAN_LEAD) begin
          // whitespace only
          r.accepted = scan_mode != MODE_U32;
        end else if (scan_phase == SCAN_DIGIT || scan_phase == SCAN_TRAIL) begin
          case (scan_mode)
            MODE_U32: fits = scan_neg ? scan_mag == 64'd0 : scan_mag <= 64'hFFFF_FFFF;
            MODE_S32: fits = scan_mag <= (scan_neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
            default:  fits = scan_mag <= (scan_neg ? 64'h8000_0000_0000_0000
                                                   : 64'h7FFF_FFFF_FFFF_FFFF);
          endcase
          if (fits && !scan_ovf) begin
            r.accepted = 1'b1;
            r.value    = scan_neg ? -scan_mag : scan_mag;
          end
        end
      end
      parse_due.push_back(r);
      strings_sent++;
      scan_phase = SCAN_LEAD;
      scan_neg   = 1'b0;
      scan_mag   = '0;
      scan_ovf   = 1'b0;
      scan_seen  = 1'b0;
    end
  endtask

  // One input transaction, after a random gap
  task automatic send_item(input logic [7:0] c, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk) push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push         <= 1'b1;
    in_char_code <= c;
    in_is_end    <= last;
    do @(posedge clk); while (full);
    chars_sent++;
    parse_char(c, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  // Stop sending and let every due result come out
  task automatic wait_idle();
    @(negedge clk) push <= 1'b0;
    while (parse_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk) cfg_we <= 1'b0;
    scan_mode = m;
  endtask

  function automatic text_t make_text();
    text_t t;
    string num;
    int pick;
    pick = $urandom_range(0, 99);
    // byte noise
    if (pick < 10) begin
      repeat ($urandom_range(0, 6)) t.push_back(8'($urandom_range(0, 255)));
      return t;
    end
    repeat ($urandom_range(0, 2)) t.push_back(blank_bytes[$urandom_range(0, 5)]);
    case ($urandom_range(0, 5))
      0: t.push_back(CH_PLUS);
      1, 2: t.push_back(CH_MIN);
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      num = bound_texts[$urandom_range(0, 11)];
      for (int i = 0; i < num.len(); i++) t.push_back(num[i]);
    end else begin
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 24 : 10))
        t.push_back(CH_0 + 8'($urandom_range(0, 9)));
    end
    repeat ($urandom_range(0, 2)) t.push_back(blank_bytes[$urandom_range(0, 5)]);
    // broken string: one stray byte somewhere
    if (pick < 30) t.insert($urandom_range(0, t.size()), 8'($urandom_range(0, 255)));
    return t;
  endfunction

  // Tests
  task automatic test_corner_cases();
    // signed 32-bit straight from reset
    send_item(8'h00, 1'b1);
    send_text("-0");
    send_text(" \t");
    send_text("+ 5");
    send_item("1", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hA5, 1'b1);
    wait_idle();
    write_mode(MODE_U32);
    send_text("+1");
    send_text(" ");
    wait_idle();
    write_mode(MODE_SPARE);
    send_text("-9");
  endtask

  task automatic test_mode_switch_mid_string();
    wait_idle();
    write_mode(MODE_S32);
    send_item(CH_MIN, 1'b0);
    wait_idle();
    // the sign was taken in signed mode, the digit and the end in unsigned
    write_mode(MODE_U32);
    send_item("5", 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_strings();
    logic [1:0] modes [4] = '{MODE_S32, MODE_U32, MODE_S64, MODE_SPARE};
    text_t t;
    int target;
    foreach (modes[m]) begin
      wait_idle();
      write_mode(modes[m]);
      target = chars_sent + 170;
      while (chars_sent < target) begin
        calm = $urandom_range(0, 4) == 0;
        t = make_text();
        foreach (t[i]) send_item(t[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
      calm = 1'b0;
    end
  endtask

  task automatic test_result_backpressure();
    wait_idle();
    write_mode(MODE_S32);
    hold_req = 1'b1;
    calm     = 1'b1;
    repeat (64) begin
      send_item("5", 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
    calm = 1'b0;
    wait_idle();
  endtask

  // Result side: random pop gaps, one long hold-off on request
  initial begin
    int w;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        w = HOLD_CYCLES;
      end else begin
        w = calm ? 0 : $urandom_range(0, 11);
      end
      if (w > 0) begin
        @(negedge clk) pop <= 1'b0;
        repeat (w - 1) @(negedge clk);
      end
      @(negedge clk) pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Result checking
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (parse_due.size() == 0) begin
        $error("result with nothing due: accepted %0b value %0d", out_accepted, out_value);
        err_count++;
      end else begin
        due_head = parse_due.pop_front();
        if (out_accepted !== due_head.accepted) begin
          $error("accepted: expected %0b, got %0b", due_head.accepted, out_accepted);
          err_count++;
        end
        if (out_value !== due_head.value) begin
          $error("value: expected %0d, got %0d", due_head.value, out_value);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (push && full) stall_cycles++;
    if (!rst_n || (push && !full) || (pop && !empty)) quiet = 0;
    else quiet++;
    if (quiet == QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("tb_decimal_text_to_integer: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    push         = 1'b0;
    in_char_code = '0;
    in_is_end    = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = MODE_S32;
    calm         = 1'b0;
    hold_req     = 1'b0;
    scan_mode    = MODE_S32;
    scan_phase   = SCAN_LEAD;
    scan_neg     = 1'b0;
    scan_mag     = '0;
    scan_ovf     = 1'b0;
    scan_seen    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_corner_cases();
    test_mode_switch_mid_string();
    test_random_strings();
    test_result_backpressure();

    wait_idle();
    repeat (10) @(posedge clk);
    if (parse_due.size() != 0) begin
      $error("%0d results never arrived", parse_due.size());
      err_count++;
    end
    $display("%0d characters in %0d strings over all four mode codes, %0d results checked",
             chars_sent, strings_sent, results_seen);
    $display("input stalled %0d cycles while results were held back", stall_cycles);
    if (err_count == 0) begin
      $display("tb_decimal_text_to_integer: done, clean");
    end else begin
      $display("tb_decimal_text_to_integer: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/dtti_pkg.sv
sv/dtti_front.sv
sv/dtti_back.sv
sv/decimal_text_to_integer.sv
verif/tb_decimal_text_to_integer.sv
